/* rtl/epf_pkg.sv */
package epf_pkg;

    localparam int FRAME_W        = 640;
    localparam int FRAME_H        = 480;
    localparam int TIME_BITS      = 32;
    localparam int FLOW_FRAC_BITS = 16;

    localparam int X_W        = 10;
    localparam int Y_W        = 9;
    localparam int PIX_DEPTH  = FRAME_W * FRAME_H;
    localparam int ADDR_W     = $clog2(PIX_DEPTH);
    localparam int STALE_W    = 31;
    localparam int MIN_TAPS_W = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int FLOW_W     = 32;

    // neighborhood sums
    localparam int SW_W  = 4;
    localparam int SS_W  = 5;
    localparam int SUM_W = TIME_BITS + 4;
    localparam int CF_W  = 9;

    // fit arithmetic
    localparam int DET_W  = SUM_W + 12;
    localparam int PROD_W = 2 * DET_W;
    localparam int DEN_W  = PROD_W + 1;
    localparam int NUM_W  = PROD_W + FLOW_FRAC_BITS;
    localparam int REM_W  = DEN_W + 1;
    localparam int CNT_W  = $clog2(NUM_W);

    localparam logic [STALE_W-1:0]    STALE_RESET    = STALE_W'(20000);
    localparam logic [MIN_TAPS_W-1:0] MIN_TAPS_RESET = MIN_TAPS_W'(3);

    localparam logic [CFG_IDX_W-1:0] CFG_STALE_WINDOW = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TAPS     = 1'd1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GATHER,
        ST_DRAIN,
        ST_WRITE,
        ST_FIT,
        ST_RESULT
    } top_state_t;

    typedef enum logic [3:0] {
        F_IDLE,
        F_COF,
        F_DET,
        F_CHK,
        F_MUL_LD,
        F_MUL_RUN,
        F_DIV_LD,
        F_DIV_RUN,
        F_DONE
    } fit_state_t;

    typedef struct packed {
        logic        [SW_W-1:0]  sw;
        logic signed [SS_W-1:0]  sx;
        logic signed [SS_W-1:0]  sy;
        logic signed [SS_W-1:0]  sxx;
        logic signed [SS_W-1:0]  sxy;
        logic signed [SS_W-1:0]  syy;
        logic signed [SUM_W-1:0] st;
        logic signed [SUM_W-1:0] sxt;
        logic signed [SUM_W-1:0] syt;
    } epf_sums_t;

    typedef struct packed {
        logic                     valid;
        logic signed [FLOW_W-1:0] fx;
        logic signed [FLOW_W-1:0] fy;
    } epf_fit_res_t;

endpackage

/* rtl/epf_fit.sv */
module epf_fit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  epf_pkg::epf_sums_t                sums,
    input  logic [epf_pkg::MIN_TAPS_W-1:0]    min_taps,
    output logic                              done,
    output epf_pkg::epf_fit_res_t             result
);
    import epf_pkg::*;

    fit_state_t state_reg, state_next;

    logic signed [CF_W-1:0]  c0_reg, c1_reg, c2_reg;
    logic signed [DET_W-1:0] e0_reg, e1_reg, e2_reg;
    logic signed [DET_W-1:0] det_reg, deta_reg, detb_reg;
    logic [DET_W-1:0]        maga_reg, magb_reg, magd_reg;
    logic [PROD_W-1:0]       acc_reg, mcand_reg, na_reg, nb_reg;
    logic [DET_W-1:0]        mplier_reg;
    logic [DEN_W-1:0]        den_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [NUM_W-1:0]        quo_reg, numsh_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [1:0]              sel_reg;
    epf_fit_res_t            res_reg;

    logic signed [SS_W-1:0]  swi;
    logic [PROD_W-1:0]       acc_next;
    logic [REM_W-1:0]        r2;
    logic                    ge;
    logic [REM_W-1:0]        rem_next;
    logic [NUM_W-1:0]        quo_next;
    logic                    neg;
    logic [NUM_W-1:0]        lim;
    logic [NUM_W-1:0]        qsat;
    logic [FLOW_W-1:0]       comp;
    logic                    reject;
    logic                    mul_last, div_last;

    assign swi = $signed({1'b0, sums.sw});

    always_comb
    begin
        acc_next = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;
        r2       = {rem_reg[REM_W-2:0], numsh_reg[NUM_W-1]};
        ge       = r2 >= REM_W'(den_reg);
        rem_next = ge ? r2 - REM_W'(den_reg) : r2;
        quo_next = {quo_reg[NUM_W-2:0], ge};
        neg      = (sel_reg[0] ? detb_reg[DET_W-1] : deta_reg[DET_W-1]) ^ det_reg[DET_W-1];
        lim      = neg ? NUM_W'(64'h8000_0000) : NUM_W'(64'h7FFF_FFFF);
        qsat     = (quo_next > lim) ? lim : quo_next;
        comp     = neg ? FLOW_W'(0) - qsat[FLOW_W-1:0] : qsat[FLOW_W-1:0];
        reject   = (SW_W'(sums.sw) < min_taps) || (det_reg == '0)
                   || ((deta_reg == '0) && (detb_reg == '0));
        mul_last = cnt_reg == CNT_W'(DET_W - 1);
        div_last = cnt_reg == CNT_W'(NUM_W - 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        done       = 1'b0;
        unique case (state_reg)
            F_IDLE:    if (start) state_next = F_COF;
            F_COF:     state_next = F_DET;
            F_DET:     state_next = F_CHK;
            F_CHK:     state_next = reject ? F_DONE : F_MUL_LD;
            F_MUL_LD:  state_next = F_MUL_RUN;
            F_MUL_RUN:
                if (mul_last)
                    state_next = (sel_reg == 2'd3) ? F_DIV_LD : F_MUL_LD;
            F_DIV_LD:  state_next = F_DIV_RUN;
            F_DIV_RUN:
                if (div_last)
                    state_next = sel_reg[0] ? F_DONE : F_DIV_LD;
            F_DONE:
            begin
                done       = 1'b1;
                state_next = F_IDLE;
            end
            default:   state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            F_IDLE:
            begin
                res_reg <= '0;
                sel_reg <= 2'd0;
            end
            F_COF:
            begin
                c0_reg <= sums.syy * swi - sums.sy * sums.sy;
                c1_reg <= sums.sxy * swi - sums.sy * sums.sx;
                c2_reg <= sums.sxy * sums.sy - sums.syy * sums.sx;
                e0_reg <= sums.syt * swi - sums.sy * sums.st;
                e1_reg <= sums.syt * sums.sy - sums.syy * sums.st;
                e2_reg <= sums.sxy * sums.st - sums.syt * sums.sx;
            end
            F_DET:
            begin
                det_reg  <= sums.sxx * c0_reg - sums.sxy * c1_reg + sums.sx * c2_reg;
                deta_reg <= sums.sxt * c0_reg - sums.sxy * e0_reg + sums.sx * e1_reg;
                detb_reg <= sums.sxx * e0_reg - sums.sxt * c1_reg + sums.sx * e2_reg;
            end
            F_CHK:
            begin
                maga_reg <= deta_reg[DET_W-1] ? DET_W'(0) - deta_reg : deta_reg;
                magb_reg <= detb_reg[DET_W-1] ? DET_W'(0) - detb_reg : detb_reg;
                magd_reg <= det_reg[DET_W-1] ? DET_W'(0) - det_reg : det_reg;
            end
            F_MUL_LD:
            begin
                acc_reg <= '0;
                cnt_reg <= '0;
                unique case (sel_reg)
                    2'd0:    begin mcand_reg <= PROD_W'(maga_reg); mplier_reg <= maga_reg; end
                    2'd1:    begin mcand_reg <= PROD_W'(magb_reg); mplier_reg <= magb_reg; end
                    2'd2:    begin mcand_reg <= PROD_W'(maga_reg); mplier_reg <= magd_reg; end
                    default: begin mcand_reg <= PROD_W'(magb_reg); mplier_reg <= magd_reg; end
                endcase
            end
            F_MUL_RUN:
            begin
                acc_reg    <= acc_next;
                mcand_reg  <= {mcand_reg[PROD_W-2:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[DET_W-1:1]};
                cnt_reg    <= cnt_reg + CNT_W'(1);
                if (mul_last)
                begin
                    unique case (sel_reg)
                        2'd0:    den_reg <= DEN_W'(acc_next);
                        2'd1:    den_reg <= den_reg + DEN_W'(acc_next);
                        2'd2:    na_reg  <= acc_next;
                        default: nb_reg  <= acc_next;
                    endcase
                    sel_reg <= (sel_reg == 2'd3) ? 2'd0 : sel_reg + 2'd1;
                end
            end
            F_DIV_LD:
            begin
                rem_reg   <= '0;
                quo_reg   <= '0;
                cnt_reg   <= '0;
                numsh_reg <= {(sel_reg[0] ? nb_reg : na_reg), FLOW_FRAC_BITS'(0)};
            end
            F_DIV_RUN:
            begin
                rem_reg   <= rem_next;
                quo_reg   <= quo_next;
                numsh_reg <= {numsh_reg[NUM_W-2:0], 1'b0};
                cnt_reg   <= cnt_reg + CNT_W'(1);
                if (div_last)
                begin
                    if (sel_reg[0])
                    begin
                        res_reg.fy    <= comp;
                        res_reg.valid <= 1'b1;
                    end
                    else
                        res_reg.fx <= comp;
                    sel_reg <= sel_reg + 2'd1;
                end
            end
            F_DONE:  ;
            default: ;
        endcase
    end

    assign result = res_reg;

endmodule

/* rtl/event_plane_fit_normal_flow.sv */
// Normal optical flow from polarity events by local plane fitting.
// Input channel: one event beat (event_x, event_y, event_polarity, event_time)
// is taken when in_valid is high and in_stall is low. Output channel: one
// result beat per event (flow_valid, flow_x, flow_y, pixel_x, pixel_y), taken
// when out_valid is high and out_stall is low.
// Per-pixel time and polarity live in one single-port-write memory of
// FRAME_W*FRAME_H words. An interior event reads its 3x3 neighborhood one tap
// a cycle plus a drain step, then the fit runs on a shared shift-add
// multiplier (four products) and a restoring divider (two quotients). The
// block takes no new event until the result is loaded; border events only
// write their pixel and off-frame events go straight to the result. The
// multiplier and divider loops set the rate. After reset the block sweeps
// the memory to zero, one pixel a cycle, with in_stall high; configuration
// writes are taken then. A finished result sits in the output register; the
// next event is accepted while it waits, and the block holds its following
// result until out_stall drops.
module event_plane_fit_normal_flow (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [epf_pkg::X_W-1:0]            event_x,
    input  logic [epf_pkg::Y_W-1:0]            event_y,
    input  logic                               event_polarity,
    input  logic [31:0]                        event_time,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               flow_valid,
    output logic signed [epf_pkg::FLOW_W-1:0]  flow_x,
    output logic signed [epf_pkg::FLOW_W-1:0]  flow_y,
    output logic [epf_pkg::X_W-1:0]            pixel_x,
    output logic [epf_pkg::Y_W-1:0]            pixel_y,
    input  logic                               cfg_we,
    input  logic [epf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [epf_pkg::STALE_W-1:0]        cfg_data
);
    import epf_pkg::*;

    localparam int MEM_W = TIME_BITS + 1;

    // pixel store: {polarity, time}
    logic [MEM_W-1:0] mem [PIX_DEPTH];
    logic [MEM_W-1:0] rd_data_reg;

    top_state_t state_reg, state_next;

    logic [STALE_W-1:0]    stale_reg;
    logic [MIN_TAPS_W-1:0] min_taps_reg;
    logic [ADDR_W-1:0]     clr_reg;
    logic [1:0]            r_reg, c_reg, rd_r_reg, rd_c_reg;
    logic                  rd_pend_reg;
    logic                  out_valid_reg;

    // event payload
    logic [X_W-1:0]        x_reg;
    logic [Y_W-1:0]        y_reg;
    logic                  p_reg;
    logic [TIME_BITS-1:0]  t_reg;
    logic [ADDR_W-1:0]     base_reg;
    epf_sums_t             sums_reg, sums_next;
    epf_fit_res_t          res_reg, fit_res;
    epf_fit_res_t          out_res_reg;
    logic [X_W-1:0]        out_x_reg;
    logic [Y_W-1:0]        out_y_reg;

    logic                  accept, out_load, issue, fit_start, fit_done;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr, rd_addr, row_off;
    logic [MEM_W-1:0]      mem_wdata;
    logic                  in_frame, interior;

    logic                  center;
    logic [TIME_BITS-1:0]  tap_time, age;
    logic                  tap_pol, tap_ok;
    logic signed [SS_W-1:0]  dx, dy;
    logic signed [SUM_W-1:0] age_s;

    assign accept   = in_valid && !in_stall;
    assign in_frame = (event_x < X_W'(FRAME_W)) && (event_y < Y_W'(FRAME_H));
    assign interior = (event_x != '0) && (event_y != '0)
                      && (event_x < X_W'(FRAME_W - 1)) && (event_y < Y_W'(FRAME_H - 1));

    epf_fit u_fit (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (fit_start),
        .sums     (sums_reg),
        .min_taps (min_taps_reg),
        .done     (fit_done),
        .result   (fit_res)
    );

    // ---- neighborhood read address ----
    always_comb
    begin
        unique case (r_reg)
            2'd0:    row_off = '0;
            2'd1:    row_off = ADDR_W'(FRAME_W);
            2'd2:    row_off = ADDR_W'(2 * FRAME_W);
            default: row_off = '0;
        endcase
        rd_addr = base_reg + row_off + ADDR_W'(c_reg) - ADDR_W'(FRAME_W + 1);
    end

    // ---- tap evaluation on returning read data ----
    always_comb
    begin
        center   = (rd_r_reg == 2'd1) && (rd_c_reg == 2'd1);
        tap_time = center ? t_reg : rd_data_reg[TIME_BITS-1:0];
        tap_pol  = center ? p_reg : rd_data_reg[TIME_BITS];
        age      = t_reg - tap_time;
        age_s    = $signed(SUM_W'(age));
        dx       = $signed(SS_W'(rd_c_reg)) - SS_W'(1);
        dy       = $signed(SS_W'(rd_r_reg)) - SS_W'(1);
        tap_ok   = rd_pend_reg && (tap_time != '0) && (tap_pol == p_reg)
                   && !age[TIME_BITS-1] && (age <= TIME_BITS'(stale_reg));

        sums_next = sums_reg;
        if (tap_ok)
        begin
            sums_next.sw  = sums_reg.sw + SW_W'(1);
            sums_next.sx  = sums_reg.sx + dx;
            sums_next.sy  = sums_reg.sy + dy;
            sums_next.sxx = sums_reg.sxx + dx * dx;
            sums_next.sxy = sums_reg.sxy + dx * dy;
            sums_next.syy = sums_reg.syy + dy * dy;
            sums_next.st  = sums_reg.st - age_s;
            unique case (rd_c_reg)
                2'd0:    sums_next.sxt = sums_reg.sxt + age_s;
                2'd2:    sums_next.sxt = sums_reg.sxt - age_s;
                default: sums_next.sxt = sums_reg.sxt;
            endcase
            unique case (rd_r_reg)
                2'd0:    sums_next.syt = sums_reg.syt + age_s;
                2'd2:    sums_next.syt = sums_reg.syt - age_s;
                default: sums_next.syt = sums_reg.syt;
            endcase
        end
    end

    // ---- control ----
    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        issue      = 1'b0;
        fit_start  = 1'b0;
        out_load   = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = base_reg;
        mem_wdata  = {p_reg, t_reg};
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                if (clr_reg == ADDR_W'(PIX_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (!in_frame)
                        state_next = ST_RESULT;
                    else if (!interior)
                        state_next = ST_WRITE;
                    else
                        state_next = ST_GATHER;
                end
            end
            ST_GATHER:
            begin
                issue = 1'b1;
                if ((r_reg == 2'd2) && (c_reg == 2'd2))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                mem_we     = 1'b1;
                fit_start  = 1'b1;
                state_next = ST_FIT;
            end
            ST_WRITE:
            begin
                mem_we     = 1'b1;
                state_next = ST_RESULT;
            end
            ST_FIT:
                if (fit_done)
                    state_next = ST_RESULT;
            ST_RESULT:
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            stale_reg     <= STALE_RESET;
            min_taps_reg  <= MIN_TAPS_RESET;
            r_reg         <= '0;
            c_reg         <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + ADDR_W'(1);
            if (cfg_we)
            begin
                if (cfg_index == CFG_STALE_WINDOW)
                    stale_reg <= cfg_data;
                else if (cfg_index == CFG_MIN_TAPS)
                    min_taps_reg <= cfg_data[MIN_TAPS_W-1:0];
            end
            if (accept)
            begin
                r_reg <= '0;
                c_reg <= '0;
            end
            else if (issue)
            begin
                c_reg <= (c_reg == 2'd2) ? 2'd0 : c_reg + 2'd1;
                if (c_reg == 2'd2)
                    r_reg <= r_reg + 2'd1;
            end
            rd_pend_reg <= issue;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // ---- datapath ----
    always_ff @(posedge clk)
    begin
        rd_r_reg <= r_reg;
        rd_c_reg <= c_reg;
        if (accept)
        begin
            x_reg    <= event_x;
            y_reg    <= event_y;
            p_reg    <= event_polarity;
            t_reg    <= event_time[TIME_BITS-1:0];
            base_reg <= ADDR_W'(event_y) * ADDR_W'(FRAME_W) + ADDR_W'(event_x);
            sums_reg <= '0;
            res_reg  <= '0;
        end
        else
            sums_reg <= sums_next;
        if ((state_reg == ST_FIT) && fit_done)
            res_reg <= fit_res;
        if (out_load)
        begin
            out_res_reg <= res_reg;
            out_x_reg   <= x_reg;
            out_y_reg   <= y_reg;
        end
    end

    // ---- pixel memory ----
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[rd_addr];
    end

    assign out_valid  = out_valid_reg;
    assign flow_valid = out_res_reg.valid;
    assign flow_x     = out_res_reg.fx;
    assign flow_y     = out_res_reg.fy;
    assign pixel_x    = out_x_reg;
    assign pixel_y    = out_y_reg;

endmodule

/* sim/event_plane_fit_normal_flow_tb.sv */
`timescale 1ns / 100ps

module event_plane_fit_normal_flow_tb;
    import epf_pkg::*;

    // one expected result beat
    typedef struct {
        logic                     valid;
        logic signed [FLOW_W-1:0] fx;
        logic signed [FLOW_W-1:0] fy;
        logic [X_W-1:0]           px;
        logic [Y_W-1:0]           py;
    } flow_beat_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [X_W-1:0]           event_x;
    logic [Y_W-1:0]           event_y;
    logic                     event_polarity;
    logic [31:0]              event_time;
    logic                     out_valid;
    logic                     out_stall;
    logic                     flow_valid;
    logic signed [FLOW_W-1:0] flow_x;
    logic signed [FLOW_W-1:0] flow_y;
    logic [X_W-1:0]           pixel_x;
    logic [Y_W-1:0]           pixel_y;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [STALE_W-1:0]       cfg_data;

    // shadow copy of the pixel surfaces and the registers
    bit [31:0]         shadow_time [0:PIX_DEPTH-1];
    bit                shadow_pol  [0:PIX_DEPTH-1];
    bit [STALE_W-1:0]  window_us;
    bit [MIN_TAPS_W-1:0] taps_needed;

    flow_beat_t        pending_flow[$];
    int                errors;
    bit                no_gaps;     // sender runs back to back
    int                hold_cycles; // long receiver hold-off, set by a test
    int                rx_wait;

    event_plane_fit_normal_flow u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog: clear pass plus ~1250 events, taken several times over
    initial
    begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    // num*det/den in Q16.16, truncated toward zero, saturated
    function automatic logic [31:0] flow_q16(longint num, longint det, logic [127:0] den);
        logic [127:0] n;
        logic [127:0] q;
        logic [127:0] lim;
        bit           neg;
        if (num == 0)
            return 32'd0;
        neg = (num < 0) != (det < 0);
        n   = (128'(magnitude(num)) * 128'(magnitude(det))) << FLOW_FRAC_BITS;
        q   = n / den;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (q > lim)
            q = lim;
        return neg ? -q[31:0] : q[31:0];
    endfunction

    // update the surfaces and fit the plane for one event
    function automatic flow_beat_t fit_normal_flow(int x, int y, bit p, logic [31:0] t);
        flow_beat_t   r;
        int           idx;
        logic [31:0]  tap;
        logic [31:0]  age;
        longint       dt, sw, sx, sy, sxx, sxy, syy, st, sxt, syt;
        longint       c0, c1, c2, det, da, db;
        logic [127:0] den;
        r.valid = 0; r.fx = 0; r.fy = 0; r.px = X_W'(x); r.py = Y_W'(y);
        if (x >= FRAME_W || y >= FRAME_H)
            return r;
        shadow_time[y*FRAME_W + x] = t;
        shadow_pol[y*FRAME_W + x]  = p;
        if (x < 1 || y < 1 || x >= FRAME_W-1 || y >= FRAME_H-1)
            return r;
        sw = 0; sx = 0; sy = 0; sxx = 0; sxy = 0; syy = 0; st = 0; sxt = 0; syt = 0;
        for (int dy = -1; dy <= 1; dy++)
        begin
            for (int dx = -1; dx <= 1; dx++)
            begin
                idx = (y+dy)*FRAME_W + x + dx;
                tap = shadow_time[idx];
                age = t - tap;
                // never fired, other polarity, in the future or stale
                if (tap == 0 || shadow_pol[idx] != p)
                    continue;
                if (age[31] || age > {1'b0, window_us})
                    continue;
                dt = -longint'(age);
                sw++; sx += dx; sy += dy;
                sxx += dx*dx; sxy += dx*dy; syy += dy*dy;
                st += dt; sxt += dx*dt; syt += dy*dt;
            end
        end
        if (sw < taps_needed)
            return r;
        c0  = syy*sw - sy*sy;
        c1  = sxy*sw - sy*sx;
        c2  = sxy*sy - syy*sx;
        det = sxx*c0 - sxy*c1 + sx*c2;
        if (det == 0)
            return r;
        da = sxt*c0 - sxy*(syt*sw - sy*st) + sx*(syt*sy - syy*st);
        db = sxx*(syt*sw - sy*st) - sxt*c1 + sx*(sxy*st - syt*sx);
        if (da == 0 && db == 0)
            return r;   // flat plane
        den = 128'(magnitude(da))*128'(magnitude(da)) + 128'(magnitude(db))*128'(magnitude(db));
        r.valid = 1;
        r.fx = flow_q16(da, det, den);
        r.fy = flow_q16(db, det, den);
        return r;
    endfunction

    // one event beat; valid drops after the accepting edge, a zero gap
    // raises it again at once so beats still run back to back
    task automatic send_event(int x, int y, bit p, logic [31:0] t);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        event_x        = X_W'(x);
        event_y        = Y_W'(y);
        event_polarity = p;
        event_time     = t;
        in_valid       = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        pending_flow.push_back(fit_normal_flow(x, y, p, t));
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // registers change only with the block drained
    task automatic write_config(logic [STALE_W-1:0] stale, logic [MIN_TAPS_W-1:0] taps);
        in_valid = 1'b0;
        while (pending_flow.size() != 0)
            @(negedge clk);
        repeat (600) @(negedge clk);  // margin only: every fit is over once its result has left
        cfg_we = 1'b1; cfg_index = CFG_STALE_WINDOW; cfg_data = stale;
        @(negedge clk);
        cfg_index = CFG_MIN_TAPS; cfg_data = STALE_W'(taps);
        @(negedge clk);
        cfg_we = 1'b0;
        window_us   = stale;
        taps_needed = taps;
    endtask

    // 3x3 patch fired in raster order on a tilted plane, then the center again
    task automatic send_plane_patch(int cx, int cy, logic [31:0] base, int gx, int gy,
                                    bit p, int flip_pct);
        bit pol;
        for (int dy = -1; dy <= 1; dy++)
        begin
            for (int dx = -1; dx <= 1; dx++)
            begin
                pol = ($urandom_range(0, 99) < flip_pct) ? ~p : p;
                send_event(cx+dx, cy+dy, pol,
                           base + 32'(gx*dx + gy*dy + 4000 + $urandom_range(0, 40)));
            end
        end
        send_event(cx, cy, p, base + 32'(9000 + $urandom_range(0, 200)));
    endtask

    task automatic test_border_and_offframe();
        send_event(0, 0, 1, 32'd100);
        send_event(FRAME_W-1, FRAME_H-1, 0, 32'hFFFF_FFFF);
        send_event(FRAME_W-1, 0, 1, 32'd5);
        send_event(0, FRAME_H-1, 0, 32'd7);
        send_event(1023, 511, 1, 32'hAAAA_5555);   // off frame, all-ones coordinates
        send_event(FRAME_W, 10, 0, 32'd9);
        send_event(10, FRAME_H, 1, 32'd9);
    endtask

    task automatic test_plane_fits();
        send_plane_patch(50, 50, 32'd1000, 150, -60, 1, 0);
        // flat patch: every tap at one time
        send_event(70, 70, 1, 32'd5000);
        send_event(71, 70, 1, 32'd5000);
        send_event(70, 71, 1, 32'd5000);
        send_event(71, 71, 1, 32'd5000);
        // wrap-around age, then a tap stamped in the future
        send_event(80, 80, 0, 32'hFFFF_FF00);
        send_event(81, 80, 0, 32'hFFFF_FFA0);
        send_event(80, 81, 0, 32'h0000_0100);
        send_event(81, 81, 0, 32'hFFFF_FF80);
        // event time zero: center tap reads as never fired
        send_event(81, 81, 0, 32'd0);
    endtask

    task automatic test_random_phase(int count);
        int sent;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                if ($urandom_range(0, 99) < 70)
                    send_plane_patch($urandom_range(100, 116), $urandom_range(200, 216),
                                     $urandom, $urandom_range(0, 6000) - 3000,
                                     $urandom_range(0, 6000) - 3000, $urandom_range(0, 1), 12);
                else
                    send_plane_patch($urandom_range(1, FRAME_W-2), $urandom_range(1, FRAME_H-2),
                                     $urandom, $urandom_range(0, 400000) - 200000,
                                     $urandom_range(0, 400000) - 200000, $urandom_range(0, 1), 5);
                sent += 10;
            end
            else
            begin
                // stray event anywhere, off frame included
                send_event($urandom_range(0, 1023), $urandom_range(0, 511), $urandom_range(0, 1),
                           $urandom);
                sent++;
            end
            no_gaps = ($urandom_range(0, 9) == 0);
        end
        no_gaps = 0;
    endtask

    task automatic test_output_hold();
        hold_cycles = 3000;
        no_gaps = 1;
        for (int i = 0; i < 20; i++)
            send_event($urandom_range(1, 8), $urandom_range(1, 8), 1, 32'd100 + 32'(i*10));
        no_gaps = 0;
    endtask

    // receiver stall: per-beat random wait plus the long hold-off
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            out_stall <= 1'b1;
        end
        else if (rx_wait > 0)
        begin
            rx_wait--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // result checker
    always @(posedge clk)
    begin
        flow_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            rx_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (pending_flow.size() == 0)
            begin
                $error("result beat with none expected");
                errors++;
            end
            else
            begin
                want = pending_flow.pop_front();
                if (flow_valid !== want.valid)
                begin
                    $error("flow_valid exp %0d got %0d", want.valid, flow_valid);
                    errors++;
                end
                if (flow_x !== want.fx)
                begin
                    $error("flow_x exp %0d got %0d", want.fx, flow_x);
                    errors++;
                end
                if (flow_y !== want.fy)
                begin
                    $error("flow_y exp %0d got %0d", want.fy, flow_y);
                    errors++;
                end
                if (pixel_x !== want.px)
                begin
                    $error("pixel_x exp %0d got %0d", want.px, pixel_x);
                    errors++;
                end
                if (pixel_y !== want.py)
                begin
                    $error("pixel_y exp %0d got %0d", want.py, pixel_y);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int waited;
        errors = 0; no_gaps = 0; hold_cycles = 0; rx_wait = 0;
        rst_n = 1'b0; in_valid = 1'b0; event_x = '0; event_y = '0;
        event_polarity = 1'b0; event_time = '0; out_stall = 1'b0;
        cfg_we = 1'b0; cfg_index = CFG_STALE_WINDOW; cfg_data = '0;
        window_us = STALE_RESET; taps_needed = MIN_TAPS_RESET;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // reset values first, memory clear runs behind in_stall
        test_border_and_offframe();
        test_plane_fits();
        test_random_phase(250);
        test_output_hold();

        write_config(31'h7FFF_FFFF, 4'd1);
        test_plane_fits();
        test_random_phase(250);

        write_config(31'd0, 4'd9);
        test_random_phase(100);

        write_config(31'd3000, 4'd0);
        test_random_phase(200);

        write_config(31'd500000, 4'd15);
        test_random_phase(100);

        write_config(31'($urandom_range(0, 300000)), 4'($urandom_range(2, 9)));
        test_random_phase(350);

        in_valid = 1'b0;
        waited = 0;
        while (pending_flow.size() != 0 && waited < 200000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (600) @(negedge clk);
        if (errors == 0 && pending_flow.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* filelist.f */
rtl/epf_pkg.sv
rtl/epf_fit.sv
rtl/event_plane_fit_normal_flow.sv
sim/event_plane_fit_normal_flow_tb.sv
